>>> hw/rtl/smrq_pkg.sv
// Shared types and codes for the slotted message ring queue.
// Used by the front end, the job queue, the back end and the top level.
package smrq_pkg;

  localparam int LEN_W      = 7;   // message length / max_len field width
  localparam int SLOT_IDX_W = 8;   // slot index carried in a job (up to 256 slots)
  localparam int JOBQ_DEPTH = 4;   // front-to-back job queue entries, power of two
  localparam int POPS_W     = $clog2(JOBQ_DEPTH + 2);

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_STATUS = 3'd4
  } action_t;

  localparam logic [3:0] ST_PUSH_OK      = 4'd0;
  localparam logic [3:0] ST_PUSH_FULL    = 4'd1;
  localparam logic [3:0] ST_PUSH_STOPPED = 4'd2;
  localparam logic [3:0] ST_PUSH_BADLEN  = 4'd3;
  localparam logic [3:0] ST_POP_BYTE     = 4'd4;
  localparam logic [3:0] ST_POP_EMPTY    = 4'd5;
  localparam logic [3:0] ST_POP_STOPPED  = 4'd6;
  localparam logic [3:0] ST_POP_TOO_LONG = 4'd7;
  localparam logic [3:0] ST_STATUS       = 4'd8;

  // refusal codes of a push in progress; same values as the push statuses
  localparam logic [1:0] REF_NONE    = 2'd0;
  localparam logic [1:0] REF_FULL    = 2'd1;
  localparam logic [1:0] REF_STOPPED = 2'd2;
  localparam logic [1:0] REF_BADLEN  = 2'd3;

  typedef enum logic {
    FS_IDLE,
    FS_POP_WAIT
  } front_state_t;

  // one unit of work for the back end: a single result beat or a pop stream
  typedef struct packed {
    logic                  stream;
    logic [3:0]            status;
    logic                  is_full;
    logic                  is_empty;
    logic [SLOT_IDX_W-1:0] slot;
    logic [LEN_W-1:0]      len;
  } job_t;

endpackage

>>> hw/rtl/smrq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module smrq_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/smrq_front.sv
// Front end: accepts command beats, owns the queue pointers, stop flag, push
// staging and slot lengths, writes pushed bytes and posts jobs for the back end.
// Depends on smrq_pkg and smrq_ram.
module smrq_front #(
  parameter int  SLOTS      = 16,
  parameter int  SLOT_BYTES = 64,
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int BI_W       = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
  localparam int ADDR_W     = IDX_W + BI_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         action,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  logic [6:0]         max_len,
  output logic               job_enq,
  output smrq_pkg::job_t     job,
  input  logic               jobq_full,
  output logic               bw_en,
  output logic [ADDR_W-1:0]  bw_addr,
  output logic [7:0]         bw_data,
  input  logic               stream_done
);
  import smrq_pkg::*;

  localparam int PTR_W  = $clog2(SLOTS) + 1;
  localparam int NPHYS  = 1 << IDX_W;

  front_state_t       state, state_next;
  logic [PTR_W-1:0]   wp, wp_next, rp, rp_next;
  logic               stop_flag, stop_flag_next;
  logic [LEN_W-1:0]   staged, staged_next;
  logic [1:0]         refused, refused_next;
  logic [NPHYS-1:0]   len_valid, len_valid_next;
  logic [POPS_W-1:0]  pops_out, pops_next;
  logic [LEN_W-1:0]   pop_max;

  logic [IDX_W-1:0]   wslot, rslot;
  logic               q_full, q_empty, cmd_accept;
  logic [1:0]         ref_cur, ref_new;
  logic               staged_room;
  logic [LEN_W-1:0]   staged_inc, len_rd, len_eff, lim;
  logic               lw_en, lr_en, pops_inc;

  assign wslot   = IDX_W'(wp % SLOTS);
  assign rslot   = IDX_W'(rp % SLOTS);
  assign q_full  = (wp ^ rp) == PTR_W'(SLOTS);
  assign q_empty = wp == rp;

  // pushes wait while a popped message may still be read out of the byte store
  assign cmd_stall  = (state != FS_IDLE) || jobq_full
                      || ((action == ACT_PUSH) && (pops_out != '0));
  assign cmd_accept = cmd_valid && !cmd_stall;

  assign ref_cur     = (staged == '0) ? (q_full ? (stop_flag ? REF_STOPPED : REF_FULL)
                                                : REF_NONE)
                                      : refused;
  assign staged_room = staged < LEN_W'(SLOT_BYTES);
  assign ref_new     = (!staged_room && (ref_cur == REF_NONE)) ? REF_BADLEN : ref_cur;
  assign staged_inc  = staged_room ? staged + 1'b1 : staged;

  assign bw_addr = {wslot, BI_W'(staged)};
  assign bw_data = data_byte;

  assign len_eff = len_valid[rslot] ? len_rd : '0;
  assign lim     = (pop_max > LEN_W'(SLOT_BYTES)) ? LEN_W'(SLOT_BYTES) : pop_max;

  smrq_ram #(
    .WIDTH (LEN_W),
    .DEPTH (NPHYS)
  ) u_len_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (wslot),
    .wdata (staged_inc),
    .re    (lr_en),
    .raddr (rslot),
    .rdata (len_rd)
  );

  always_comb begin
    state_next     = state;
    wp_next        = wp;
    rp_next        = rp;
    stop_flag_next = stop_flag;
    staged_next    = staged;
    refused_next   = refused;
    len_valid_next = len_valid;
    job_enq        = 1'b0;
    job            = '0;
    bw_en          = 1'b0;
    lw_en          = 1'b0;
    lr_en          = 1'b0;
    pops_inc       = 1'b0;

    case (state)
      FS_IDLE: begin
        if (cmd_accept) begin
          case (action)
            ACT_PUSH: begin
              bw_en = staged_room && (ref_cur == REF_NONE);
              if (!last) begin
                staged_next  = staged_inc;
                refused_next = ref_new;
              end else begin
                staged_next  = '0;
                refused_next = REF_NONE;
                job_enq      = 1'b1;
                job.status   = {2'b00, ref_new};
                if (ref_new == REF_NONE) begin
                  lw_en                 = 1'b1;
                  len_valid_next[wslot] = 1'b1;
                  wp_next               = wp + 1'b1;
                end
              end
            end
            ACT_POP: begin
              lr_en      = 1'b1;
              state_next = FS_POP_WAIT;
            end
            ACT_STOP: begin
              stop_flag_next = 1'b1;
              job_enq        = 1'b1;
              job.status     = ST_STATUS;
            end
            ACT_CLEAR: begin
              wp_next        = '0;
              rp_next        = '0;
              stop_flag_next = 1'b0;
              len_valid_next = '0;
              staged_next    = '0;
              refused_next   = REF_NONE;
              job_enq        = 1'b1;
              job.status     = ST_STATUS;
            end
            ACT_STATUS: begin
              job_enq    = 1'b1;
              job.status = ST_STATUS;
            end
            default: begin
            end
          endcase
        end
      end
      FS_POP_WAIT: begin
        // length read was issued at the accept edge
        if (!jobq_full) begin
          state_next = FS_IDLE;
          if (q_empty) begin
            job_enq    = 1'b1;
            job.status = stop_flag ? ST_POP_STOPPED : ST_POP_EMPTY;
          end else if (len_eff > lim) begin
            job_enq    = 1'b1;
            job.status = ST_POP_TOO_LONG;
          end else begin
            rp_next = rp + 1'b1;
            if (len_eff != '0) begin
              job_enq    = 1'b1;
              pops_inc   = 1'b1;
              job.stream = 1'b1;
              job.status = ST_POP_BYTE;
              job.slot   = SLOT_IDX_W'(rslot);
              job.len    = len_eff;
            end
          end
        end
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase

    job.is_full  = (wp_next ^ rp_next) == PTR_W'(SLOTS);
    job.is_empty = wp_next == rp_next;

    pops_next = pops_out;
    if (pops_inc && !stream_done) begin
      pops_next = pops_out + 1'b1;
    end else if (!pops_inc && stream_done) begin
      pops_next = pops_out - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FS_IDLE;
      wp        <= '0;
      rp        <= '0;
      stop_flag <= 1'b0;
      staged    <= '0;
      refused   <= REF_NONE;
      len_valid <= '0;
      pops_out  <= '0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      rp        <= rp_next;
      stop_flag <= stop_flag_next;
      staged    <= staged_next;
      refused   <= refused_next;
      len_valid <= len_valid_next;
      pops_out  <= pops_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept && (action == ACT_POP)) begin
      pop_max <= max_len;
    end
  end

  a_no_write_under_stream: assert property (@(posedge clk) disable iff (rst)
    bw_en |-> (pops_out == '0))
    else $error("byte store written while a pop stream is pending");

  a_staged_bound: assert property (@(posedge clk) disable iff (rst)
    staged <= LEN_W'(SLOT_BYTES))
    else $error("staged byte count beyond slot size");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  a_pops_bound: assert property (@(posedge clk) disable iff (rst)
    (job_enq && job.stream) |-> (pops_out <= POPS_W'(JOBQ_DEPTH)))
    else $error("pending pop stream count overflow");

endmodule

>>> hw/rtl/smrq_jobq.sv
// Short job queue between the front end and the back end.
// Depends on smrq_pkg.
module smrq_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           enq,
  input  smrq_pkg::job_t enq_job,
  input  logic           deq,
  output smrq_pkg::job_t head,
  output logic           full,
  output logic           avail
);
  import smrq_pkg::*;

  localparam int QA_W = $clog2(JOBQ_DEPTH);
  localparam int QP_W = QA_W + 1;

  job_t            mem [JOBQ_DEPTH];
  logic [QP_W-1:0] wr, rd;

  assign full  = (wr ^ rd) == QP_W'(JOBQ_DEPTH);
  assign avail = wr != rd;
  assign head  = mem[rd[QA_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
    end else begin
      if (enq) begin
        wr <= wr + 1'b1;
      end
      if (deq) begin
        rd <= rd + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr[QA_W-1:0]] <= enq_job;
    end
  end

endmodule

>>> hw/rtl/smrq_back.sv
// Back end: takes jobs, streams popped bytes out of the byte store and holds
// the result register. Depends on smrq_pkg.
module smrq_back #(
  parameter int  SLOTS      = 16,
  parameter int  SLOT_BYTES = 64,
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int BI_W       = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
  localparam int ADDR_W     = IDX_W + BI_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_avail,
  input  smrq_pkg::job_t    job,
  output logic              job_deq,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              stream_done,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [3:0]        status,
  output logic [7:0]        data_byte_res,
  output logic              last_res,
  output logic [6:0]        msg_length,
  output logic              is_full,
  output logic              is_empty
);
  import smrq_pkg::*;

  logic                  active, pend, pend_last;
  logic [LEN_W-1:0]      idx, slen;
  logic [SLOT_IDX_W-1:0] sslot;
  logic                  sfull, sempty;
  logic                  out_free, load, issue, idle, single;

  assign out_free = !res_valid || !res_stall;
  // read data is held by the RAM until the next read, so one read in flight
  assign load     = pend && out_free;
  assign issue    = active && (!pend || load);
  assign idle     = !active && !pend;
  assign job_deq  = job_avail && idle && (job.stream || out_free);
  assign single   = job_deq && !job.stream;

  assign rd_en       = issue;
  assign rd_addr     = {sslot[IDX_W-1:0], BI_W'(idx)};
  assign stream_done = load && pend_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (job_deq && job.stream) begin
        active <= 1'b1;
      end else if (issue && (idx == slen - 1'b1)) begin
        active <= 1'b0;
      end
      if (issue) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load || single) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_deq && job.stream) begin
      idx    <= '0;
      slen   <= job.len;
      sslot  <= job.slot;
      sfull  <= job.is_full;
      sempty <= job.is_empty;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
    if (issue) begin
      pend_last <= (idx == slen - 1'b1);
    end
    if (load) begin
      status        <= ST_POP_BYTE;
      data_byte_res <= rd_data;
      last_res      <= pend_last;
      msg_length    <= slen;
      is_full       <= sfull;
      is_empty      <= sempty;
    end else if (single) begin
      status        <= job.status;
      data_byte_res <= '0;
      last_res      <= 1'b1;
      msg_length    <= '0;
      is_full       <= job.is_full;
      is_empty      <= job.is_empty;
    end
  end

  a_last_read_ends_stream: assert property (@(posedge clk) disable iff (rst)
    (pend && pend_last) |-> !active)
    else $error("stream still active after its last read");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (idx < slen))
    else $error("stream byte index past message length");

  a_stream_end: assert property (@(posedge clk) disable iff (rst)
    $fell(active) |-> (pend && pend_last))
    else $error("stream ended without a last read pending");

endmodule

>>> hw/rtl/slotted_message_ring_queue.sv
// Top level of the slotted message ring queue: front end, job queue, back end
// and the byte store RAM. Depends on smrq_pkg, smrq_ram, smrq_front,
// smrq_jobq and smrq_back.
//
//   channel  valid      stall      beat fields
//   command  cmd_valid  cmd_stall  action, data_byte, last, max_len
//   result   res_valid  res_stall  status, data_byte_res, last_res, msg_length,
//                                  is_full, is_empty
//
// A push byte, stop, clear or status query is handled by the front end when accepted.
// A pop has the front end read the length RAM, then decide; then the back end streams
// its bytes from the byte store read port, one per cycle unless the result stalls.
// Push beats stall while a popped message is still being read out.
// Reset is synchronous; the byte store is never cleared, slot lengths use valid bits.
// A stalled result holds; the job queue lets the front end run ahead.
module slotted_message_ring_queue #(
  parameter int  SLOTS      = 16,
  parameter int  SLOT_BYTES = 64,
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int BI_W       = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
  localparam int ADDR_W     = IDX_W + BI_W
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [2:0] action,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic [6:0] max_len,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [3:0] status,
  output logic [7:0] data_byte_res,
  output logic       last_res,
  output logic [6:0] msg_length,
  output logic       is_full,
  output logic       is_empty
);
  import smrq_pkg::*;

  job_t              enq_job, head_job;
  logic              job_enq, job_deq, jobq_full, jobq_avail;
  logic              bw_en, rd_en, stream_done;
  logic [ADDR_W-1:0] bw_addr, rd_addr;
  logic [7:0]        bw_data, rd_data;

  smrq_front #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .action      (action),
    .data_byte   (data_byte),
    .last        (last),
    .max_len     (max_len),
    .job_enq     (job_enq),
    .job         (enq_job),
    .jobq_full   (jobq_full),
    .bw_en       (bw_en),
    .bw_addr     (bw_addr),
    .bw_data     (bw_data),
    .stream_done (stream_done)
  );

  smrq_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .enq     (job_enq),
    .enq_job (enq_job),
    .deq     (job_deq),
    .head    (head_job),
    .full    (jobq_full),
    .avail   (jobq_avail)
  );

  smrq_ram #(
    .WIDTH (8),
    .DEPTH ((1 << IDX_W) << BI_W)
  ) u_byte_ram (
    .clk   (clk),
    .we    (bw_en),
    .waddr (bw_addr),
    .wdata (bw_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  smrq_back #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_avail     (jobq_avail),
    .job           (head_job),
    .job_deq       (job_deq),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .stream_done   (stream_done),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .data_byte_res (data_byte_res),
    .last_res      (last_res),
    .msg_length    (msg_length),
    .is_full       (is_full),
    .is_empty      (is_empty)
  );

endmodule
